@@ rtl/mrt_pkg.sv @@
// Package for the modulo reservation table: sizes, derived widths, request and
// register codes, and helpers that saturate the configured interval and slot limits.
// No dependencies.
package mrt_pkg;

    localparam int NUM_RES   = 4;
    localparam int MAX_II    = 16;
    localparam int MAX_SLOTS = 4;

    localparam int ID_W   = 8;
    localparam int T_W    = 16;
    localparam int OP_W   = 3;
    localparam int RSEL_W = 2;
    localparam int IV_W   = 5;
    localparam int LIM_W  = 4;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 5;
    localparam int RIDX_W  = 3;

    localparam int RES_W    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int ROW_W    = (MAX_II > 1) ? $clog2(MAX_II) : 1;
    localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int II_W     = $clog2(MAX_II + 1);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int ROWS     = NUM_RES * MAX_II;
    localparam int ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_BITS = MAX_SLOTS * ID_W;
    localparam int TB_W     = $clog2(T_W);

    localparam logic [OP_W-1:0] OP_CHECK    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd4;

    localparam logic [RIDX_W-1:0] REG_INTERVAL = 3'd0;
    localparam logic [RIDX_W-1:0] REG_LIMIT0   = 3'd1;
    localparam logic [RIDX_W-1:0] REG_LAST     = 3'd4;

    typedef logic [MAX_SLOTS-1:0][ID_W-1:0] row_t;

    typedef struct packed {
        logic             unc;
        logic [CNT_W-1:0] cnt;
    } lim_t;

    function automatic logic [II_W-1:0] eff_ii(input logic [IV_W-1:0] iv);
        logic [II_W-1:0] r;
        if (iv == '0) begin
            r = II_W'(1);
        end else if (int'(iv) > MAX_II) begin
            r = II_W'(MAX_II);
        end else begin
            r = II_W'(iv);
        end
        return r;
    endfunction

    function automatic lim_t eff_lim(input logic signed [LIM_W-1:0] l);
        lim_t r;
        r.unc = 1'b0;
        r.cnt = '0;
        if (l < 0) begin
            r.unc = 1'b1;
        end else if (int'(l) > MAX_SLOTS) begin
            r.cnt = CNT_W'(MAX_SLOTS);
        end else begin
            r.cnt = CNT_W'(l);
        end
        return r;
    endfunction

    function automatic logic [MAX_SLOTS-1:0] slot_mask(input lim_t l);
        logic [MAX_SLOTS-1:0] m;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            m[s] = !l.unc && (s < int'(l.cnt));
        end
        return m;
    endfunction

endpackage

@@ rtl/mrt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/modulo_reservation_table_core.sv @@
// Modulo reservation table: one RAM row per (resource, time slot mod interval).
// Depends on mrt_pkg and mrt_ram.
//
// One item at a time; the next input can be taken in the same cycle in which the
// result is accepted. Check/insert: the bit-serial remainder unit (16 steps), then
// row read, evaluate and output register. Remove scans interval rows, contains
// NUM_RES * interval rows, one RAM row per cycle. Lookup reads a single row.
// Trivial requests skip the table. A result stalled on m_ready holds off the next item.
// Reset (aresetn, synchronous) and a write to any listed register mark every row
// empty at once through per-row valid bits.
module modulo_reservation_table_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mrt_pkg::PADDR_W-1:0]        paddr,
    input  logic [mrt_pkg::DATA_W-1:0]         pwdata,
    output logic [mrt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mrt_pkg::OP_W-1:0]           s_operation,
    input  logic [mrt_pkg::ID_W-1:0]           s_op_id,
    input  logic [mrt_pkg::RSEL_W-1:0]         s_resource,
    input  logic [mrt_pkg::T_W-1:0]            s_start_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_flag,
    output logic [mrt_pkg::ID_W-1:0]           m_occupant
);

    import mrt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MOD    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_LAST   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [II_W-1:0]          rem_reg, rem_next;
    logic [TB_W-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [RES_W-1:0]         scan_res_reg, scan_res_next;
    logic [ROW_W-1:0]         scan_row_reg, scan_row_next;
    logic                     eval_pend_reg, eval_pend_next;
    logic [ADDR_W-1:0]        eval_addr_reg;
    logic [RES_W-1:0]         eval_res_reg;
    logic                     rd_ok_reg;
    logic                     flag_reg, flag_next;
    logic [ID_W-1:0]          occ_reg, occ_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_flag_reg;
    logic [ID_W-1:0]          m_occ_reg;
    logic [IV_W-1:0]          interval_reg;
    logic signed [LIM_W-1:0]  limit_reg [NUM_RES];
    logic [ROWS-1:0]          row_valid_reg;

    logic                     cfg_wr;
    logic [RIDX_W-1:0]        cfg_idx;
    logic [II_W-1:0]          ii;
    logic                     out_free;
    logic                     s_fire;
    logic                     s_unc;
    lim_t                     s_lim;

    logic [ADDR_W-1:0]        raddr;
    logic [ROW_BITS-1:0]      ram_q;
    logic                     we;
    row_t                     wrow;
    row_t                     rd_row;
    lim_t                     e_lim;
    logic [MAX_SLOTS-1:0]     e_mask, e_hit, e_empty, e_nz;
    logic [SLOT_W-1:0]        first_empty, first_nz;
    logic                     row_last, res_last, scan_last, multi;
    logic [II_W:0]            trial;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign ii      = eff_ii(interval_reg);

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= IV_W'(1);
            for (int r = 0; r < NUM_RES; r++) begin
                limit_reg[r] <= '1;
            end
        end else if (cfg_wr) begin
            if (cfg_idx == REG_INTERVAL) begin
                interval_reg <= pwdata[IV_W-1:0];
            end
            for (int r = 0; r < NUM_RES; r++) begin
                if (int'(cfg_idx) == int'(REG_LIMIT0) + r) begin
                    limit_reg[r] <= pwdata[LIM_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx == REG_INTERVAL) begin
            prdata = DATA_W'(interval_reg);
        end
        for (int r = 0; r < NUM_RES; r++) begin
            if (int'(cfg_idx) == int'(REG_LIMIT0) + r) begin
                prdata = DATA_W'(unsigned'(limit_reg[r]));
            end
        end
    end

    // table RAM, one row of slots per entry
    assign raddr = ADDR_W'(int'(scan_res_reg) * MAX_II + int'(scan_row_reg));

    mrt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (eval_addr_reg),
        .wdata (wrow),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // row evaluation on read data
    assign rd_row = rd_ok_reg ? row_t'(ram_q) : '0;
    assign e_lim  = eff_lim(limit_reg[eval_res_reg]);
    assign e_mask = slot_mask(e_lim);

    always_comb begin
        first_empty = '0;
        first_nz    = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            e_hit[s]   = e_mask[s] && (rd_row[s] == id_reg);
            e_empty[s] = e_mask[s] && (rd_row[s] == '0);
            e_nz[s]    = e_mask[s] && (rd_row[s] != '0);
        end
        for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
            if (e_empty[s]) begin
                first_empty = $bits(first_empty)'(s);
            end
            if (e_nz[s]) begin
                first_nz = $bits(first_nz)'(s);
            end
        end
    end

    // request intake decisions
    assign s_unc = int'(s_resource) >= NUM_RES;
    always_comb begin
        s_lim = eff_lim(limit_reg[RES_W'(s_resource)]);
        if (s_unc) begin
            s_lim.unc = 1'b1;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign multi    = (op_reg == OP_REMOVE) || (op_reg == OP_CONTAINS);
    assign row_last = int'(scan_row_reg) == int'(ii) - 1;
    assign res_last = (op_reg != OP_CONTAINS) || (int'(scan_res_reg) == NUM_RES - 1);
    assign scan_last = !multi || (row_last && res_last);
    assign trial    = {rem_reg, t_reg[T_W-1]};

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        scan_res_next  = scan_res_reg;
        scan_row_next  = scan_row_reg;
        eval_pend_next = 1'b0;
        flag_next      = flag_reg;
        occ_next       = occ_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        we             = 1'b0;
        wrow           = rd_row;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next       = s_operation;
                    id_next       = s_op_id;
                    t_next        = s_start_time;
                    rem_next      = '0;
                    bit_cnt_next  = '0;
                    scan_res_next = RES_W'(s_resource);
                    scan_row_next = '0;
                    flag_next     = 1'b0;
                    occ_next      = '0;
                    state_next    = ST_FINISH;
                    case (s_operation)
                        OP_CHECK: begin
                            if (s_lim.unc) begin
                                flag_next = 1'b0;
                            end else if (s_op_id == '0) begin
                                flag_next = 1'b1;
                            end else begin
                                state_next = ST_MOD;
                            end
                        end
                        OP_INSERT: begin
                            if (s_lim.unc || s_lim.cnt == '0) begin
                                flag_next = 1'b1;
                            end else if (s_op_id != '0) begin
                                state_next = ST_MOD;
                            end
                        end
                        OP_REMOVE: begin
                            flag_next = 1'b1;
                            if (!s_lim.unc && s_lim.cnt != '0 && s_op_id != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CONTAINS: begin
                            scan_res_next = '0;
                            if (s_op_id != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_LOOKUP: begin
                            scan_row_next = s_start_time[ROW_W-1:0];
                            if (!s_lim.unc && s_lim.cnt != '0
                                && int'(s_start_time) < int'(ii)) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            flag_next = 1'b0;
                        end
                    endcase
                end
            end

            // one remainder bit per cycle, MSB first
            ST_MOD: begin
                if (trial >= {1'b0, ii}) begin
                    rem_next = II_W'(trial - {1'b0, ii});
                end else begin
                    rem_next = II_W'(trial);
                end
                t_next       = t_reg << 1;
                bit_cnt_next = TB_W'(bit_cnt_reg + 1'b1);
                if (int'(bit_cnt_reg) == T_W - 1) begin
                    scan_row_next = rem_next[ROW_W-1:0];
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                eval_pend_next = 1'b1;
                if (scan_last) begin
                    state_next = ST_LAST;
                end else if (row_last) begin
                    scan_row_next = '0;
                    scan_res_next = RES_W'(scan_res_reg + 1'b1);
                end else begin
                    scan_row_next = ROW_W'(scan_row_reg + 1'b1);
                end
            end

            ST_LAST: begin
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // evaluate the row read in the previous cycle, write back if needed
        if (eval_pend_reg) begin
            case (op_reg)
                OP_CHECK: begin
                    flag_next = (|e_hit) || !(|e_empty);
                end
                OP_INSERT: begin
                    if (!(|e_hit) && (|e_empty)) begin
                        wrow[first_empty] = id_reg;
                        we        = 1'b1;
                        flag_next = 1'b1;
                    end else begin
                        flag_next = 1'b0;
                    end
                end
                OP_REMOVE: begin
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        if (e_hit[s]) begin
                            wrow[s] = '0;
                        end
                    end
                    we = |e_hit;
                end
                OP_CONTAINS: begin
                    flag_next = flag_reg || (|e_hit);
                end
                OP_LOOKUP: begin
                    flag_next = |e_nz;
                    occ_next  = (|e_nz) ? rd_row[first_nz] : '0;
                end
                default: begin
                    flag_next = flag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            eval_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            eval_pend_reg <= eval_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr && cfg_idx <= REG_LAST) begin
                row_valid_reg <= '0;
            end else if (we) begin
                row_valid_reg[eval_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        t_reg         <= t_next;
        rem_reg       <= rem_next;
        bit_cnt_reg   <= bit_cnt_next;
        scan_res_reg  <= scan_res_next;
        scan_row_reg  <= scan_row_next;
        flag_reg      <= flag_next;
        occ_reg       <= occ_next;
        eval_addr_reg <= raddr;
        eval_res_reg  <= scan_res_reg;
        rd_ok_reg     <= row_valid_reg[raddr];
        if (state_reg == ST_FINISH && out_free) begin
            m_flag_reg <= flag_reg;
            m_occ_reg  <= occ_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_flag     = m_flag_reg;
    assign m_occupant = m_occ_reg;

endmodule
